### rtl/bpmc_pkg.sv
// ----------------------------------------------------------------------------
// bpmc_pkg
// Shared types and constants for the button press mode controller.
// ----------------------------------------------------------------------------
package bpmc_pkg;

    localparam int CNT_W     = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_BTN   = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 4'd1;

    localparam logic [CFG_W-1:0] MIN_PRESS_RESET = 10'd2;
    localparam logic [CFG_W-1:0] HOLD_RESET      = 10'd100;

    localparam int NUM_MODES_DEFAULT      = 6;
    localparam int NUM_DEEP_MODES_DEFAULT = 4;

    // button slots
    localparam int BTN_MODE     = 0;
    localparam int BTN_CAROUSEL = 1;
    localparam int BTN_SLEEP    = 2;
    localparam int BTN_STATS    = 3;

    typedef struct packed {
        logic mode_button;
        logic carousel_button;
        logic sleep_button;
        logic stats_button;
        logic usb_power;
    } item_t;

    typedef struct packed {
        logic [2:0] display_mode;
        logic [1:0] deep_mode;
        logic       carousel_on;
        logic       deep_sleep_on;
        logic       mode_event;
        logic       carousel_event;
        logic       stats_event;
        logic       sleep_event;
        logic       deep_layout;
    } result_t;

    // per-button status for the current item
    typedef struct packed {
        logic             now;
        logic             rise;
        logic             rel;
        logic             qual;
        logic [CNT_W-1:0] count;
    } btn_stat_t;

endpackage

### rtl/bpmc_btn.sv
// ----------------------------------------------------------------------------
// bpmc_btn
// One button: previous level, saturating hold counter and press qualifier.
// ----------------------------------------------------------------------------
module bpmc_btn (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           level,
    input  logic [bpmc_pkg::CFG_W-1:0]     min_press_ticks,
    output bpmc_pkg::btn_stat_t            stat
);

    logic                        prev_reg;
    logic [bpmc_pkg::CNT_W-1:0]  count_reg;
    logic [bpmc_pkg::CNT_W-1:0]  count_next;

    always_comb
    begin
        count_next = count_reg;
        if (level && !prev_reg)
        begin
            count_next = '0;
        end
        else if (prev_reg && (count_reg != bpmc_pkg::COUNT_MAX))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        stat.now   = level;
        stat.rise  = level && !prev_reg;
        stat.rel   = prev_reg && !level;
        stat.qual  = prev_reg && !level && (count_next >= min_press_ticks);
        stat.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            prev_reg  <= level;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/bpmc_mode.sv
// ----------------------------------------------------------------------------
// bpmc_mode
// Sleep hold, display indices, carousel flag and the result for each item.
// ----------------------------------------------------------------------------
module bpmc_mode #(
    parameter int NUM_MODES      = bpmc_pkg::NUM_MODES_DEFAULT,
    parameter int NUM_DEEP_MODES = bpmc_pkg::NUM_DEEP_MODES_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    advance,
    input  logic                                    usb_power,
    input  logic [bpmc_pkg::CFG_W-1:0]              hold_ticks,
    input  bpmc_pkg::btn_stat_t [bpmc_pkg::NUM_BTN-1:0] stat,
    output bpmc_pkg::result_t                       result_next
);

    logic       hold_fired_reg;
    logic       hold_fired_next;
    logic [2:0] normal_reg;
    logic [2:0] normal_next;
    logic [1:0] deep_reg;
    logic [1:0] deep_next;
    logic       carousel_reg;
    logic       carousel_next;
    logic       deep_sleep_reg;
    logic       deep_sleep_next;

    logic       fired_base;
    logic       fire;
    logic       layout;
    logic       mode_qual;
    logic [3:0] normal_inc;
    logic [2:0] deep_inc;

    always_comb
    begin
        // a new press clears the fired mark before the threshold test
        fired_base = stat[bpmc_pkg::BTN_SLEEP].rise ? 1'b0 : hold_fired_reg;
        fire = stat[bpmc_pkg::BTN_SLEEP].now && !fired_base &&
               (stat[bpmc_pkg::BTN_SLEEP].count >= hold_ticks);
        hold_fired_next = stat[bpmc_pkg::BTN_SLEEP].rel ? 1'b0 : (fire | fired_base);

        deep_sleep_next = deep_sleep_reg ^ fire;
        layout          = deep_sleep_next && !usb_power;
        mode_qual       = stat[bpmc_pkg::BTN_MODE].qual;

        normal_next = fire ? 3'd0 : normal_reg;
        deep_next   = fire ? 2'd0 : deep_reg;
        normal_inc  = {1'b0, normal_next} + 4'd1;
        deep_inc    = {1'b0, deep_next} + 3'd1;

        if (mode_qual)
        begin
            if (layout)
            begin
                deep_next = (deep_inc >= 3'(NUM_DEEP_MODES)) ? 2'd0 : deep_inc[1:0];
            end
            else
            begin
                normal_next = (normal_inc >= 4'(NUM_MODES)) ? 3'd0 : normal_inc[2:0];
            end
        end

        carousel_next = carousel_reg ^ stat[bpmc_pkg::BTN_CAROUSEL].qual;

        result_next.display_mode   = normal_next;
        result_next.deep_mode      = deep_next;
        result_next.carousel_on    = carousel_next;
        result_next.deep_sleep_on  = deep_sleep_next;
        result_next.mode_event     = mode_qual;
        result_next.carousel_event = stat[bpmc_pkg::BTN_CAROUSEL].qual;
        result_next.stats_event    = stat[bpmc_pkg::BTN_STATS].qual;
        result_next.sleep_event    = fire;
        result_next.deep_layout    = layout;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_fired_reg <= 1'b0;
            normal_reg     <= '0;
            deep_reg       <= '0;
            carousel_reg   <= 1'b0;
            deep_sleep_reg <= 1'b0;
        end
        else if (advance)
        begin
            hold_fired_reg <= hold_fired_next;
            normal_reg     <= normal_next;
            deep_reg       <= deep_next;
            carousel_reg   <= carousel_next;
            deep_sleep_reg <= deep_sleep_next;
        end
    end

    a_sleep_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && fire) |=> (deep_sleep_reg != $past(deep_sleep_reg)))
        else $error("sleep fire did not toggle deep sleep");

    a_sleep_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && fire && !mode_qual) |=> (normal_reg == 3'd0 && deep_reg == 2'd0))
        else $error("sleep fire did not clear display indices");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, normal_reg} < 4'(NUM_MODES)))
        else $error("normal index out of range");

    a_deep_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, deep_reg} < 3'(NUM_DEEP_MODES)))
        else $error("deep index out of range");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(normal_reg) && $stable(deep_reg) &&
                      $stable(carousel_reg) && $stable(deep_sleep_reg)))
        else $error("mode state changed without an item");

endmodule

### rtl/button_press_mode_controller_top.sv
// ----------------------------------------------------------------------------
// button_press_mode_controller_top
// Poll-tick button controller: short presses, sleep hold, display modes.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item is held in the input register; its result is
// then captured in the result register.
// Throughput: one item per cycle while result_stall is low; the update is
// a single pass of logic between the input and result registers.
// Reset: asynchronous, active low; clears all button and mode state and
// loads min_press_ticks = 2, hold_ticks = 100.
module button_press_mode_controller_top #(
    parameter int NUM_MODES      = bpmc_pkg::NUM_MODES_DEFAULT,
    parameter int NUM_DEEP_MODES = bpmc_pkg::NUM_DEEP_MODES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  bpmc_pkg::item_t                    item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output bpmc_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpmc_pkg::CFG_W-1:0]         cfg_data
);

    logic [bpmc_pkg::CFG_W-1:0] min_press_reg;
    logic [bpmc_pkg::CFG_W-1:0] hold_reg;

    bpmc_pkg::item_t    item_reg;
    logic               item_valid_reg;
    bpmc_pkg::result_t  result_reg;
    bpmc_pkg::result_t  result_next;
    logic               result_valid_reg;

    logic               advance;
    logic               load;
    logic [bpmc_pkg::NUM_BTN-1:0]                levels;
    bpmc_pkg::btn_stat_t [bpmc_pkg::NUM_BTN-1:0] stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_press_reg <= bpmc_pkg::MIN_PRESS_RESET;
            hold_reg      <= bpmc_pkg::HOLD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bpmc_pkg::CFG_MIN_PRESS: min_press_reg <= cfg_data;
                bpmc_pkg::CFG_HOLD:      hold_reg      <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // move the held item on whenever the result slot is free or draining
    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign load       = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        levels[bpmc_pkg::BTN_MODE]     = item_reg.mode_button;
        levels[bpmc_pkg::BTN_CAROUSEL] = item_reg.carousel_button;
        levels[bpmc_pkg::BTN_SLEEP]    = item_reg.sleep_button;
        levels[bpmc_pkg::BTN_STATS]    = item_reg.stats_button;
    end

    for (genvar g = 0; g < bpmc_pkg::NUM_BTN; g++)
    begin : g_btn
        bpmc_btn u_btn (
            .clk             (clk),
            .rst_n           (rst_n),
            .advance         (advance),
            .level           (levels[g]),
            .min_press_ticks (min_press_reg),
            .stat            (stat[g])
        );
    end

    bpmc_mode #(
        .NUM_MODES      (NUM_MODES),
        .NUM_DEEP_MODES (NUM_DEEP_MODES)
    ) u_mode (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .usb_power   (item_reg.usb_power),
        .hold_ticks  (hold_reg),
        .stat        (stat),
        .result_next (result_next)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
